FILE: sv/svm_pkg.sv
// Shared opcodes, status codes, fixed-point constants and a saturation helper for the stack VM execute unit.
`default_nettype none
package svm_pkg;

  // Instruction opcodes.
  typedef logic [4:0] op_t;
  localparam op_t OP_PUSH    = 5'd0;
  localparam op_t OP_POP     = 5'd1;
  localparam op_t OP_POPREG  = 5'd2;
  localparam op_t OP_DUPE    = 5'd3;
  localparam op_t OP_SWAP    = 5'd4;
  localparam op_t OP_ADD     = 5'd5;
  localparam op_t OP_SUB     = 5'd6;
  localparam op_t OP_MUL     = 5'd7;
  localparam op_t OP_DIV     = 5'd8;
  localparam op_t OP_INC     = 5'd9;
  localparam op_t OP_DEC     = 5'd10;
  localparam op_t OP_SIZE    = 5'd11;
  localparam op_t OP_JMP     = 5'd12;
  localparam op_t OP_JGT     = 5'd13;
  localparam op_t OP_JGE     = 5'd14;
  localparam op_t OP_JLT     = 5'd15;
  localparam op_t OP_JLE     = 5'd16;
  localparam op_t OP_JEQ     = 5'd17;
  localparam op_t OP_JNE     = 5'd18;
  localparam op_t OP_MOVSET  = 5'd19;
  localparam op_t OP_MOVPUSH = 5'd20;
  localparam op_t OP_READ    = 5'd21;
  localparam op_t OP_WRITE   = 5'd22;
  localparam op_t OP_CALL    = 5'd23;
  localparam op_t OP_RET     = 5'd24;
  localparam op_t OP_FSKIP   = 5'd25;

  // Result status codes.
  typedef logic [2:0] status_t;
  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_UNDER    = 3'd1;
  localparam status_t ST_OVER     = 3'd2;
  localparam status_t ST_DIV0     = 3'd3;
  localparam status_t ST_NOTFOUND = 3'd4;

  // Operand source selector codes.
  typedef logic [1:0] src_t;
  localparam src_t SRC_IMM    = 2'd0;
  localparam src_t SRC_TOP    = 2'd1;
  localparam src_t SRC_SECOND = 2'd2;

  // Q16.16 constants.
  typedef logic signed [31:0] q_t;
  localparam q_t Q_ONE = 32'sh0001_0000;
  localparam q_t Q_MAX = 32'sh7fff_ffff;
  localparam q_t Q_MIN = -32'sh7fff_ffff - 32'sh1;

  // Saturate a widened sum to the signed 32-bit range.
  function automatic q_t sat34(input logic signed [33:0] v);
    q_t r;
    if (v > 34'sh0_7fff_ffff) begin
      r = Q_MAX;
    end else if (v < -34'sh0_8000_0000) begin
      r = Q_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/svm_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
`default_nettype none
module svm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: sv/stack_vm_execute_unit_top.sv
// Top level of the stack VM execute unit: sequencer around the stack, heap and call RAMs.
`default_nettype none
// Usage:
// An item is one decoded instruction on the in_ ports. It is accepted on a
// rising edge where start is high and busy is low. Exactly one result item
// follows: out_valid is high for one cycle with status, jump, halt flag, the
// new stack top and the stack depth on the out_ ports. The receiver cannot
// stall, so the result must be taken in that cycle.
// Most instructions pass through the execute state S_EX and give their
// result in S_OUT; a new item can be accepted in the same cycle as the
// result. Swap, mult and a divide by zero that leaves entries on the stack
// also pass through S_W2 (second stack write), S_MUL (product register) or
// S_RLD (top reload) before S_OUT. Div runs a one-bit-per-cycle restoring
// divider over a 48-bit dividend in S_DIV, then writes the quotient in S_DIVF.
// The data stack RAM has one read and one write port; its read for an item
// is issued in the acceptance cycle.
// Reset (synchronous, active low) empties both stacks, clears registers and
// the halt flag, then sweeps the heap RAM to zero, one entry a cycle,
// during which busy is high.
module stack_vm_execute_unit_top #(
  parameter int STACK_DEPTH = 1024,
  parameter int REG_COUNT   = 16,
  parameter int HEAP_DEPTH  = 1024,
  parameter int CALL_DEPTH  = 64,
  localparam int CW = $clog2(STACK_DEPTH + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire svm_pkg::op_t         in_op,
  input  wire logic signed [31:0]   in_imm,
  input  wire logic [1:0]           in_src_sel,
  input  wire logic [9:0]           in_index,
  input  wire logic [15:0]          in_jump_target,
  input  wire logic                 in_target_found,
  input  wire logic [15:0]          in_here,
  input  wire logic                 in_stop_req,
  output logic                      out_valid,
  output svm_pkg::status_t          out_status,
  output logic                      out_jump_taken,
  output logic [15:0]               out_jump_to,
  output logic                      out_halted,
  output logic signed [31:0]        out_top_value,
  output logic [CW-1:0]             out_depth
);

  import svm_pkg::*;

  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int HAW = $clog2(HEAP_DEPTH);
  localparam int RAW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int CAW = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
  localparam int RCW = $clog2(CALL_DEPTH + 1);

  // Sequencer states.
  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_EX   = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_DIVF = 4'd5;
  localparam logic [3:0] S_RLD  = 4'd6;
  localparam logic [3:0] S_W2   = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  // Control state.
  logic [3:0]     state_r, state_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [RCW-1:0] rc_r, rc_nxt;
  logic           halt_r, halt_nxt;
  logic [HAW-1:0] clr_r, clr_nxt;
  logic [5:0]     cnt_r, cnt_nxt;

  // Payload and result registers.
  q_t             top_r, top_nxt;
  status_t        status_r, status_nxt;
  logic           jump_r, jump_nxt;
  logic [15:0]    jto_r, jto_nxt;
  op_t            op_r;
  q_t             imm_r;
  logic [1:0]     sel_r;
  logic [9:0]     idx_r;
  logic [15:0]    tgt_r;
  logic           found_r;
  logic [15:0]    here_r;
  logic           stop_r;
  q_t             regs_r [REG_COUNT];

  // Multiply and divide datapath registers.
  logic signed [63:0] prod_r, prod_nxt;
  logic [47:0]        dq_r, dq_nxt;
  logic [31:0]        rem_r, rem_nxt;
  logic [31:0]        dvs_r, dvs_nxt;
  logic               neg_r, neg_nxt;

  // Memory ports.
  logic             sk_we;
  logic [SAW-1:0]   sk_waddr, sk_raddr;
  logic [31:0]      sk_wdata, sk_rdata;
  logic             hp_we;
  logic [HAW-1:0]   hp_waddr, hp_raddr;
  logic [31:0]      hp_wdata, hp_rdata;
  logic             rs_we;
  logic [CAW-1:0]   rs_waddr, rs_raddr;
  logic [15:0]      rs_rdata;
  logic             rg_we;
  q_t               rg_wdata;

  // Decoded helpers.
  logic           acc;
  q_t             sdata;
  q_t             opnd;
  logic           fetch_ok;
  logic           full;
  logic           reg_ok;
  logic           heap_ok;
  q_t             regv;
  q_t             sizev;
  logic [47:0]    cnt_w;
  logic           do_push;
  q_t             push_d;
  logic           cond;
  logic [33:0]    rem_sh;
  logic           ge;
  logic [31:0]    abs_a;
  logic [31:0]    abs_b;
  logic signed [63:0] prod_sh;
  q_t             mul_q;
  q_t             div_q;

  assign busy     = !(state_r == S_IDLE || state_r == S_OUT);
  assign acc      = start && !busy;
  assign sdata    = sk_rdata;

  // Memory instances.
  svm_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(sk_we), .waddr(sk_waddr), .wdata(sk_wdata),
    .raddr(sk_raddr), .rdata(sk_rdata)
  );
  svm_ram #(.WIDTH(32), .DEPTH(HEAP_DEPTH)) u_heap (
    .clk(clk), .we(hp_we), .waddr(hp_waddr), .wdata(hp_wdata),
    .raddr(hp_raddr), .rdata(hp_rdata)
  );
  svm_ram #(.WIDTH(16), .DEPTH(CALL_DEPTH)) u_ret (
    .clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(here_r),
    .raddr(rs_raddr), .rdata(rs_rdata)
  );

  // Read addresses: operand reads go out in the acceptance cycle, the top
  // reload after a divide by zero goes out during execute.
  always_comb begin
    if (state_r == S_EX) begin
      sk_raddr = SAW'(count_r - CW'(3));
    end else if (in_op == OP_DUPE) begin
      sk_raddr = SAW'(count_r - CW'(1) - CW'(in_index));
    end else begin
      sk_raddr = SAW'(count_r - CW'(2));
    end
  end
  assign hp_raddr = HAW'(in_index);
  assign rs_raddr = CAW'(rc_r - RCW'(1));
  assign rs_waddr = CAW'(rc_r);

  // Operand selection and range checks.
  always_comb begin
    case (sel_r)
      SRC_TOP: begin
        fetch_ok = (count_r != '0);
        opnd     = top_r;
      end
      SRC_SECOND: begin
        fetch_ok = (count_r > CW'(1));
        opnd     = sdata;
      end
      default: begin
        fetch_ok = 1'b1;
        opnd     = imm_r;
      end
    endcase
  end
  assign full    = (count_r >= CW'(STACK_DEPTH));
  assign reg_ok  = ({22'd0, idx_r} < 32'(REG_COUNT));
  assign heap_ok = ({22'd0, idx_r} < 32'(HEAP_DEPTH));
  assign regv    = reg_ok ? regs_r[RAW'(idx_r)] : '0;
  assign cnt_w   = 48'(count_r);
  assign sizev   = (32'(count_r) >= 32'd32768) ? Q_MAX : q_t'({cnt_w[15:0], 16'h0});

  // Conditional jump comparison of the top against the operand.
  always_comb begin
    unique case (op_r) inside
      OP_JGT:  cond = top_r > opnd;
      OP_JGE:  cond = top_r >= opnd;
      OP_JLT:  cond = top_r < opnd;
      OP_JLE:  cond = top_r <= opnd;
      OP_JEQ:  cond = top_r == opnd;
      default: cond = top_r != opnd;
    endcase
  end

  // Divider step and operand magnitudes.
  assign rem_sh = {1'b0, rem_r, dq_r[47]};
  assign ge     = rem_sh >= {2'b00, dvs_r};
  assign abs_a  = top_r[31] ? 32'(-top_r) : 32'(top_r);
  assign abs_b  = sdata[31] ? 32'(-sdata) : 32'(sdata);

  // Product floor shift with saturation.
  assign prod_sh = prod_r >>> 16;
  assign mul_q   = (prod_sh > 64'(Q_MAX)) ? Q_MAX :
                   (prod_sh < 64'(Q_MIN)) ? Q_MIN : prod_sh[31:0];

  // Signed quotient with saturation.
  always_comb begin
    if (!neg_r) begin
      div_q = (dq_r > 48'h0000_7fff_ffff) ? Q_MAX : dq_r[31:0];
    end else begin
      div_q = (dq_r > 48'h0000_8000_0000) ? Q_MIN : q_t'(-dq_r[31:0]);
    end
  end

  // Sequencer and read-modify-write of the stack state.
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    top_nxt    = top_r;
    rc_nxt     = rc_r;
    halt_nxt   = halt_r;
    clr_nxt    = clr_r;
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    jump_nxt   = jump_r;
    jto_nxt    = jto_r;
    prod_nxt   = prod_r;
    dq_nxt     = dq_r;
    rem_nxt    = rem_r;
    dvs_nxt    = dvs_r;
    neg_nxt    = neg_r;
    sk_we      = 1'b0;
    sk_waddr   = SAW'(count_r - CW'(2));
    sk_wdata   = top_r;
    hp_we      = 1'b0;
    hp_waddr   = HAW'(idx_r);
    hp_wdata   = opnd;
    rs_we      = 1'b0;
    rg_we      = 1'b0;
    rg_wdata   = opnd;
    do_push    = 1'b0;
    push_d     = opnd;

    unique case (state_r)
      S_CLR: begin
        hp_we    = 1'b1;
        hp_waddr = clr_r;
        hp_wdata = '0;
        clr_nxt  = clr_r + HAW'(1);
        if (clr_r == HAW'(HEAP_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE, S_OUT: begin
        if (acc) begin
          state_nxt = S_EX;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EX: begin
        status_nxt = ST_OK;
        jump_nxt   = 1'b0;
        jto_nxt    = '0;
        state_nxt  = S_OUT;
        if (halt_r) begin
          // A halted machine ignores the item.
        end else if (stop_r) begin
          halt_nxt = 1'b1;
        end else begin
          unique case (op_r) inside
            OP_PUSH, OP_MOVPUSH, OP_SIZE: begin
              if (full) begin
                status_nxt = ST_OVER;
              end else if (op_r == OP_PUSH) begin
                if (!fetch_ok) begin
                  status_nxt = ST_UNDER;
                end else begin
                  do_push = 1'b1;
                  push_d  = opnd;
                end
              end else if (op_r == OP_MOVPUSH) begin
                do_push = 1'b1;
                push_d  = regv;
              end else begin
                do_push = 1'b1;
                push_d  = sizev;
              end
            end
            OP_POP, OP_POPREG: begin
              if (count_r == '0) begin
                status_nxt = ST_UNDER;
              end else begin
                count_nxt = count_r - CW'(1);
                top_nxt   = sdata;
                rg_wdata  = top_r;
                rg_we     = (op_r == OP_POPREG) && reg_ok;
              end
            end
            OP_DUPE: begin
              if (32'(idx_r) >= 32'(count_r)) begin
                status_nxt = ST_UNDER;
              end else if (full) begin
                status_nxt = ST_OVER;
              end else begin
                do_push = 1'b1;
                push_d  = sdata;
              end
            end
            [OP_SWAP:OP_DIV]: begin
              if (count_r == '0) begin
                status_nxt = ST_UNDER;
              end else if (count_r == CW'(1)) begin
                count_nxt  = '0;
                status_nxt = ST_UNDER;
              end else begin
                unique case (op_r) inside
                  OP_SWAP: begin
                    // Old top goes below, old second becomes the top.
                    sk_we     = 1'b1;
                    sk_wdata  = top_r;
                    top_nxt   = sdata;
                    state_nxt = S_W2;
                  end
                  OP_ADD, OP_SUB: begin
                    sk_we     = 1'b1;
                    sk_wdata  = (op_r == OP_ADD) ? sat34(34'(top_r) + 34'(sdata))
                                                 : sat34(34'(top_r) - 34'(sdata));
                    top_nxt   = sk_wdata;
                    count_nxt = count_r - CW'(1);
                  end
                  OP_MUL: begin
                    prod_nxt  = 64'(top_r) * 64'(sdata);
                    state_nxt = S_MUL;
                  end
                  default: begin
                    if (sdata == '0) begin
                      status_nxt = ST_DIV0;
                      count_nxt  = count_r - CW'(2);
                      if (count_r > CW'(2)) begin
                        state_nxt = S_RLD;
                      end
                    end else begin
                      dq_nxt    = {abs_a, 16'h0};
                      rem_nxt   = '0;
                      dvs_nxt   = abs_b;
                      neg_nxt   = top_r[31] ^ sdata[31];
                      cnt_nxt   = '0;
                      state_nxt = S_DIV;
                    end
                  end
                endcase
              end
            end
            OP_INC, OP_DEC: begin
              if (count_r == '0) begin
                status_nxt = ST_UNDER;
              end else begin
                sk_we    = 1'b1;
                sk_waddr = SAW'(count_r - CW'(1));
                sk_wdata = (op_r == OP_INC) ? sat34(34'(top_r) + 34'(Q_ONE))
                                            : sat34(34'(top_r) - 34'(Q_ONE));
                top_nxt  = sk_wdata;
              end
            end
            OP_JMP: begin
              if (!found_r) begin
                status_nxt = ST_NOTFOUND;
              end else begin
                jump_nxt = 1'b1;
                jto_nxt  = tgt_r;
              end
            end
            [OP_JGT:OP_JNE]: begin
              if (count_r == '0 || !fetch_ok) begin
                status_nxt = ST_UNDER;
              end else if (cond) begin
                if (!found_r) begin
                  status_nxt = ST_NOTFOUND;
                end else begin
                  jump_nxt = 1'b1;
                  jto_nxt  = tgt_r;
                end
              end
            end
            OP_MOVSET, OP_WRITE: begin
              if (!fetch_ok) begin
                status_nxt = ST_UNDER;
              end else if (op_r == OP_MOVSET) begin
                rg_we = reg_ok;
              end else begin
                hp_we = heap_ok;
              end
            end
            OP_READ: begin
              if (32'(count_r) + 32'd1 >= 32'(STACK_DEPTH)) begin
                status_nxt = ST_OVER;
              end else begin
                do_push = 1'b1;
                push_d  = heap_ok ? hp_rdata : '0;
              end
            end
            OP_CALL: begin
              if (rc_r >= RCW'(CALL_DEPTH)) begin
                status_nxt = ST_OVER;
              end else begin
                rs_we  = 1'b1;
                rc_nxt = rc_r + RCW'(1);
                if (!found_r) begin
                  status_nxt = ST_NOTFOUND;
                end else begin
                  jump_nxt = 1'b1;
                  jto_nxt  = tgt_r;
                end
              end
            end
            OP_RET: begin
              if (rc_r != '0) begin
                rc_nxt   = rc_r - RCW'(1);
                jump_nxt = 1'b1;
                jto_nxt  = rs_rdata;
              end
            end
            OP_FSKIP: begin
              if (rc_r == '0) begin
                jump_nxt = 1'b1;
                jto_nxt  = tgt_r;
              end
            end
            default: begin
              // Unused opcodes do nothing.
            end
          endcase
        end
        // Single push onto the stack.
        if (do_push) begin
          sk_we     = 1'b1;
          sk_waddr  = SAW'(count_r);
          sk_wdata  = push_d;
          top_nxt   = push_d;
          count_nxt = count_r + CW'(1);
        end
      end
      S_MUL: begin
        sk_we     = 1'b1;
        sk_wdata  = mul_q;
        top_nxt   = mul_q;
        count_nxt = count_r - CW'(1);
        state_nxt = S_OUT;
      end
      S_DIV: begin
        rem_nxt = ge ? 32'(rem_sh - {2'b00, dvs_r}) : rem_sh[31:0];
        dq_nxt  = {dq_r[46:0], ge};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd47) begin
          state_nxt = S_DIVF;
        end
      end
      S_DIVF: begin
        sk_we     = 1'b1;
        sk_wdata  = div_q;
        top_nxt   = div_q;
        count_nxt = count_r - CW'(1);
        state_nxt = S_OUT;
      end
      S_RLD: begin
        top_nxt   = sdata;
        state_nxt = S_OUT;
      end
      S_W2: begin
        sk_we     = 1'b1;
        sk_waddr  = SAW'(count_r - CW'(1));
        sk_wdata  = top_r;
        state_nxt = S_OUT;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      count_r <= '0;
      rc_r    <= '0;
      halt_r  <= 1'b0;
      clr_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rc_r    <= rc_nxt;
      halt_r  <= halt_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Register file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        regs_r[i] <= '0;
      end
    end else if (rg_we) begin
      regs_r[RAW'(idx_r)] <= rg_wdata;
    end
  end

  // Payload registers and item capture.
  always_ff @(posedge clk) begin
    top_r    <= top_nxt;
    status_r <= status_nxt;
    jump_r   <= jump_nxt;
    jto_r    <= jto_nxt;
    prod_r   <= prod_nxt;
    dq_r     <= dq_nxt;
    rem_r    <= rem_nxt;
    dvs_r    <= dvs_nxt;
    neg_r    <= neg_nxt;
    if (acc) begin
      op_r    <= in_op;
      imm_r   <= in_imm;
      sel_r   <= in_src_sel;
      idx_r   <= in_index;
      tgt_r   <= in_jump_target;
      found_r <= in_target_found;
      here_r  <= in_here;
      stop_r  <= in_stop_req;
    end
  end

  // Result item.
  assign out_valid      = (state_r == S_OUT);
  assign out_status     = status_r;
  assign out_jump_taken = jump_r;
  assign out_jump_to    = jto_r;
  assign out_halted     = halt_r;
  assign out_top_value  = (count_r != '0) ? top_r : '0;
  assign out_depth      = count_r;

endmodule
`default_nettype wire

FILE: test/tb_stack_vm_execute_unit_top.sv
// Self-checking testbench for the stack VM execute unit top level.
module tb_stack_vm_execute_unit_top;
  import svm_pkg::*;

  localparam int STK_N  = 1024;
  localparam int REG_N  = 16;
  localparam int HEAP_N = 1024;
  localparam int RET_N  = 64;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    status_t     status;
    logic        jump_taken;
    logic [15:0] jump_to;
    logic        halted;
    q_t          top_value;
    logic [10:0] depth;
  } vm_result_t;

  logic clk, rst_n, start, busy;
  op_t in_op;
  logic signed [31:0] in_imm;
  logic [1:0] in_src_sel;
  logic [9:0] in_index;
  logic [15:0] in_jump_target, in_here;
  logic in_target_found, in_stop_req;
  logic out_valid, out_jump_taken, out_halted;
  status_t out_status;
  logic [15:0] out_jump_to;
  logic signed [31:0] out_top_value;
  logic [10:0] out_depth;

  stack_vm_execute_unit_top u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_imm(in_imm), .in_src_sel(in_src_sel), .in_index(in_index),
    .in_jump_target(in_jump_target), .in_target_found(in_target_found),
    .in_here(in_here), .in_stop_req(in_stop_req),
    .out_valid(out_valid), .out_status(out_status), .out_jump_taken(out_jump_taken),
    .out_jump_to(out_jump_to), .out_halted(out_halted),
    .out_top_value(out_top_value), .out_depth(out_depth)
  );

  // Shadow machine state.
  q_t          vm_stack [STK_N];
  int          vm_count;
  q_t          vm_regs [REG_N];
  q_t          vm_heap [HEAP_N];
  logic [15:0] vm_calls [RET_N];
  int          vm_call_count;
  bit          vm_halt;

  vm_result_t pending_results[$];
  int fail_count = 0;
  int cycle_count = 0;
  int idle_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run-length guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic q_t sat_q(longint v);
    q_t r;
    if (v > 64'sd2147483647) r = Q_MAX;
    else if (v < -64'sd2147483648) r = Q_MIN;
    else r = q_t'(v);
    return r;
  endfunction

  function automatic bit vm_pop(output q_t v);
    bit ok;
    ok = vm_count > 0;
    if (ok) begin
      vm_count--;
      v = vm_stack[vm_count];
    end
    return ok;
  endfunction

  function automatic void vm_push(q_t v);
    if (vm_count < STK_N) begin
      vm_stack[vm_count] = v;
      vm_count++;
    end
  endfunction

  function automatic bit vm_operand(logic [1:0] sel, q_t imm, output q_t v);
    bit ok;
    ok = 1'b1;
    if (sel == SRC_TOP) begin
      ok = vm_count >= 1;
      if (ok) v = vm_stack[vm_count - 1];
    end else if (sel == SRC_SECOND) begin
      ok = vm_count >= 2;
      if (ok) v = vm_stack[vm_count - 2];
    end else begin
      v = imm;
    end
    return ok;
  endfunction

  // Executes one instruction on the shadow state and returns the expected result.
  function automatic vm_result_t vm_execute(op_t op, q_t imm, logic [1:0] sel,
                                            logic [9:0] idx, logic [15:0] tgt,
                                            logic found, logic [15:0] here,
                                            logic stop);
    vm_result_t r;
    q_t a, b, v, t;
    bit c, ok;
    r.status = ST_OK;
    r.jump_taken = 1'b0;
    r.jump_to = '0;
    a = '0; b = '0; v = '0;
    if (vm_halt) begin
    end else if (stop) begin
      vm_halt = 1'b1;
    end else if (op == OP_PUSH || op == OP_MOVPUSH || op == OP_SIZE) begin
      if (vm_count >= STK_N) r.status = ST_OVER;
      else if (op == OP_PUSH) begin
        if (!vm_operand(sel, imm, v)) r.status = ST_UNDER;
        else vm_push(v);
      end else if (op == OP_MOVPUSH) begin
        vm_push(idx < REG_N ? vm_regs[idx] : '0);
      end else begin
        vm_push(sat_q(longint'(vm_count) * 65536));
      end
    end else if (op == OP_POP || op == OP_POPREG) begin
      if (!vm_pop(a)) r.status = ST_UNDER;
      else if (op == OP_POPREG && idx < REG_N) vm_regs[idx] = a;
    end else if (op == OP_DUPE) begin
      if (idx >= vm_count) r.status = ST_UNDER;
      else if (vm_count >= STK_N) r.status = ST_OVER;
      else vm_push(vm_stack[vm_count - 1 - idx]);
    end else if (op >= OP_SWAP && op <= OP_DIV) begin
      ok = vm_pop(a);
      if (ok) ok = vm_pop(b);
      if (!ok) r.status = ST_UNDER;
      else if (op == OP_SWAP) begin
        vm_push(a);
        vm_push(b);
      end else if (op == OP_ADD) vm_push(sat_q(longint'(a) + longint'(b)));
      else if (op == OP_SUB) vm_push(sat_q(longint'(a) - longint'(b)));
      else if (op == OP_MUL) vm_push(sat_q((longint'(a) * longint'(b)) >>> 16));
      else if (b == 0) r.status = ST_DIV0;
      else vm_push(sat_q((longint'(a) * 65536) / longint'(b)));
    end else if (op == OP_INC || op == OP_DEC) begin
      if (!vm_pop(a)) r.status = ST_UNDER;
      else vm_push(sat_q(longint'(a) + (op == OP_INC ? 65536 : -65536)));
    end else if (op == OP_JMP) begin
      if (!found) r.status = ST_NOTFOUND;
      else begin
        r.jump_taken = 1'b1;
        r.jump_to = tgt;
      end
    end else if (op >= OP_JGT && op <= OP_JNE) begin
      if (vm_count == 0 || !vm_operand(sel, imm, v)) r.status = ST_UNDER;
      else begin
        t = vm_stack[vm_count - 1];
        case (op)
          OP_JGT: c = t > v;
          OP_JGE: c = t >= v;
          OP_JLT: c = t < v;
          OP_JLE: c = t <= v;
          OP_JEQ: c = t == v;
          default: c = t != v;
        endcase
        if (c) begin
          if (!found) r.status = ST_NOTFOUND;
          else begin
            r.jump_taken = 1'b1;
            r.jump_to = tgt;
          end
        end
      end
    end else if (op == OP_MOVSET || op == OP_WRITE) begin
      if (!vm_operand(sel, imm, v)) r.status = ST_UNDER;
      else if (op == OP_MOVSET) begin
        if (idx < REG_N) vm_regs[idx] = v;
      end else if (idx < HEAP_N) vm_heap[idx] = v;
    end else if (op == OP_READ) begin
      if (vm_count + 1 >= STK_N) r.status = ST_OVER;
      else vm_push(idx < HEAP_N ? vm_heap[idx] : '0);
    end else if (op == OP_CALL) begin
      if (vm_call_count >= RET_N) r.status = ST_OVER;
      else begin
        vm_calls[vm_call_count] = here;
        vm_call_count++;
        if (!found) r.status = ST_NOTFOUND;
        else begin
          r.jump_taken = 1'b1;
          r.jump_to = tgt;
        end
      end
    end else if (op == OP_RET) begin
      if (vm_call_count != 0) begin
        vm_call_count--;
        r.jump_taken = 1'b1;
        r.jump_to = vm_calls[vm_call_count];
      end
    end else if (op == OP_FSKIP) begin
      if (vm_call_count == 0) begin
        r.jump_taken = 1'b1;
        r.jump_to = tgt;
      end
    end
    r.halted = vm_halt;
    r.top_value = vm_count > 0 ? vm_stack[vm_count - 1] : '0;
    r.depth = 11'(vm_count);
    return r;
  endfunction

  // Result checker: every strobed result is matched against the oldest expectation.
  always @(posedge clk) begin
    vm_result_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result item");
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        if (out_status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_status);
          fail_count++;
        end
        if (out_jump_taken !== e.jump_taken) begin
          $error("jump_taken: expected %0d, got %0d", e.jump_taken, out_jump_taken);
          fail_count++;
        end
        if (out_jump_to !== e.jump_to) begin
          $error("jump_to: expected %0h, got %0h", e.jump_to, out_jump_to);
          fail_count++;
        end
        if (out_halted !== e.halted) begin
          $error("halted: expected %0d, got %0d", e.halted, out_halted);
          fail_count++;
        end
        if (out_top_value !== e.top_value) begin
          $error("top_value: expected %0h, got %0h", e.top_value, out_top_value);
          fail_count++;
        end
        if (out_depth !== e.depth) begin
          $error("depth: expected %0d, got %0d", e.depth, out_depth);
          fail_count++;
        end
      end
    end
  end

  // Sends one item; called at a falling edge and returns at a falling edge.
  task automatic send_item(op_t op, q_t imm, logic [1:0] sel, logic [9:0] idx,
                           logic [15:0] tgt, logic found, logic [15:0] here,
                           logic stop);
    int gap;
    in_op = op;
    in_imm = imm;
    in_src_sel = sel;
    in_index = idx;
    in_jump_target = tgt;
    in_target_found = found;
    in_here = here;
    in_stop_req = stop;
    start = 1'b1;
    while (busy) @(negedge clk);
    @(posedge clk);
    pending_results.insert(pending_results.size(),
                           vm_execute(op, imm, sel, idx, tgt, found, here, stop));
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(negedge clk);
    end
  endtask

  // Instruction with random side fields.
  task automatic send_op(op_t op, q_t imm, logic [1:0] sel, logic [9:0] idx, logic found);
    send_item(op, imm, sel, idx, 16'($urandom), found, 16'($urandom), 1'b0);
  endtask

  function automatic q_t rand_q();
    q_t v;
    case ($urandom_range(7))
      0: v = Q_MAX;
      1: v = Q_MIN;
      2: v = '0;
      3: v = q_t'($urandom_range(0, 8) * 65536) - q_t'(4 * 65536);
      4: v = q_t'($urandom_range(0, 2047)) - q_t'(1024);
      default: v = q_t'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [9:0] rand_index();
    logic [9:0] i;
    case ($urandom_range(5))
      0: i = 10'($urandom);
      1: i = 10'($urandom_range(1008, 1023));
      default: i = 10'($urandom_range(0, 17));
    endcase
    return i;
  endfunction

  // Program-like instruction mix: mostly stack and arithmetic work.
  function automatic op_t rand_op(int depth_now);
    op_t op;
    int pick;
    pick = $urandom_range(99);
    if (pick < 22) op = OP_PUSH;
    else if (pick < 26) op = OP_READ;
    else if (pick < 30) op = OP_MOVPUSH;
    else if (pick < 33) op = OP_SIZE;
    else if (pick < 38) op = OP_DUPE;
    else if (pick < 88) op = op_t'($urandom_range(1, 25));
    else if (pick < 92) op = op_t'($urandom_range(26, 31));
    else op = (depth_now > 1) ? OP_ADD : OP_PUSH;
    return op;
  endfunction

  task automatic send_random();
    op_t op;
    logic [9:0] idx;
    op = rand_op(vm_count);
    idx = rand_index();
    if (op == OP_DUPE && vm_count > 0 && $urandom_range(3) != 0)
      idx = 10'($urandom_range(0, vm_count - 1));
    send_item(op, rand_q(), 2'($urandom), idx, 16'($urandom),
              $urandom_range(7) != 0, 16'($urandom), 1'b0);
  endtask

  task automatic test_directed();
    send_op(OP_POP, '0, SRC_IMM, 10'd0, 1'b1);
    send_op(OP_PUSH, '0, SRC_TOP, 10'd0, 1'b1);
    send_op(OP_PUSH, Q_MAX, SRC_IMM, 10'd0, 1'b1);
    // Second operand missing: the first pop stays consumed.
    send_op(OP_ADD, '0, SRC_IMM, 10'd0, 1'b1);
    send_op(OP_PUSH, Q_MAX, SRC_IMM, 10'd0, 1'b1);
    send_op(OP_PUSH, Q_MAX, 2'd3, 10'd0, 1'b1);
    send_op(OP_ADD, '0, SRC_IMM, 10'd0, 1'b1);
    send_op(OP_INC, '0, SRC_IMM, 10'd0, 1'b1);
    send_op(OP_PUSH, Q_MIN, SRC_IMM, 10'd0, 1'b1);
    send_op(OP_DEC, '0, SRC_IMM, 10'd0, 1'b1);
    send_op(OP_SUB, '0, SRC_IMM, 10'd0, 1'b1);
    send_op(OP_PUSH, -q_t'(3), SRC_IMM, 10'd0, 1'b1);
    send_op(OP_PUSH, q_t'(32'sh0000_8000), SRC_IMM, 10'd0, 1'b1);
    send_op(OP_MUL, '0, SRC_IMM, 10'd0, 1'b1);
    send_op(OP_PUSH, '0, SRC_IMM, 10'd0, 1'b1);
    send_op(OP_PUSH, Q_ONE, SRC_IMM, 10'd0, 1'b1);
    // Divide by zero: both operands stay consumed.
    send_op(OP_DIV, '0, SRC_IMM, 10'd0, 1'b1);
    send_op(OP_PUSH, q_t'(3 * 65536), SRC_IMM, 10'd0, 1'b1);
    send_op(OP_PUSH, Q_MIN, SRC_IMM, 10'd0, 1'b1);
    send_op(OP_DIV, '0, SRC_IMM, 10'd0, 1'b1);
    send_op(OP_DUPE, '0, SRC_IMM, 10'd1023, 1'b1);
    send_op(OP_MOVSET, Q_MIN, 2'd3, 10'd15, 1'b1);
    send_op(OP_WRITE, '0, SRC_TOP, 10'd1023, 1'b1);
    send_op(OP_READ, '0, SRC_IMM, 10'd1023, 1'b1);
    send_op(OP_JMP, '0, SRC_IMM, 10'd0, 1'b0);
  endtask

  // Call nesting to the return stack limit and back.
  task automatic test_call_depth();
    send_op(OP_FSKIP, '0, SRC_IMM, 10'd0, 1'b0);
    send_op(OP_RET, '0, SRC_IMM, 10'd0, 1'b1);
    while (vm_call_count < RET_N) send_op(OP_CALL, '0, SRC_IMM, 10'd0, $urandom_range(3) != 0);
    send_op(OP_CALL, '0, SRC_IMM, 10'd0, 1'b1);
    send_op(OP_FSKIP, '0, SRC_IMM, 10'd0, 1'b1);
    while (vm_call_count > 0) send_op(OP_RET, '0, SRC_IMM, 10'd0, 1'b1);
    send_op(OP_RET, '0, SRC_IMM, 10'd0, 1'b1);
  endtask

  task automatic test_random(int n);
    repeat (n) send_random();
  endtask

  // Stop sets the halt flag; later items are ignored.
  task automatic test_halt();
    send_item(OP_PUSH, Q_ONE, SRC_IMM, 10'd0, 16'hffff, 1'b1, 16'hffff, 1'b1);
    repeat (6) send_random();
  endtask

  initial begin
    idle_pct = 34;
    rst_n = 1'b0;
    start = 1'b0;
    in_op = OP_PUSH;
    in_imm = '0;
    in_src_sel = SRC_IMM;
    in_index = '0;
    in_jump_target = '0;
    in_target_found = 1'b0;
    in_here = '0;
    in_stop_req = 1'b0;
    vm_count = 0;
    vm_call_count = 0;
    vm_halt = 1'b0;
    foreach (vm_regs[i]) vm_regs[i] = '0;
    foreach (vm_heap[i]) vm_heap[i] = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(260);
    idle_pct = 64;
    test_call_depth();
    test_random(240);
    idle_pct = 0;
    test_random(230);
    test_halt();
    start = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
